[rtl/ipid_pkg.sv]
// Shared types and constants for the incremental PID block.
`timescale 1ns / 1ps

package ipid_pkg;

  // Widths fixed by the item and register formats
  localparam int unsigned GainW  = 16;
  localparam int unsigned LimW   = 15;
  localparam int unsigned CountW = 16;
  localparam int unsigned PosW   = 16;
  localparam int unsigned ErrW   = 18;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Error magnitude beyond which one encoder turn is folded back
  localparam logic signed [ErrW-1:0] WrapThresh = 18'sd6000;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP        = 3'd0,
    CFG_KI        = 3'd1,
    CFG_KD        = 3'd2,
    CFG_INT_LIMIT = 3'd3,
    CFG_OUT_LIMIT = 3'd4,
    CFG_COUNTS    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [GainW-1:0]  kp;
    logic [GainW-1:0]  ki;
    logic [GainW-1:0]  kd;
    logic [LimW-1:0]   integral_limit;
    logic [LimW-1:0]   output_limit;
    logic [CountW-1:0] counts_per_turn;
  } ipid_cfg_t;

  typedef struct packed {
    logic                   action;
    logic signed [PosW-1:0] target;
    logic signed [PosW-1:0] measured;
  } ipid_item_t;

  typedef struct packed {
    logic signed [PosW-1:0] drive;
    logic                   clamped;
  } ipid_res_t;

endpackage

[rtl/ipid_core.sv]
// Control law datapath: wrap correction, P/I/D terms, accumulator and history.
`timescale 1ns / 1ps

module ipid_core import ipid_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,   // commit the item below to the state
  input  ipid_item_t item_i,
  input  ipid_cfg_t  cfg_i,
  output ipid_res_t  res_o
);

  localparam int unsigned AccW  = PosW + FRAC_BITS;
  localparam int unsigned ProdW = 37;  // 17-bit gain times 20-bit error
  localparam int unsigned SumW  = ((AccW > ProdW) ? AccW : ProdW) + 2;
  localparam logic [AccW:0] FracMask = (AccW+1)'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [ErrW-1:0] e1_q, e1_d;
  logic signed [ErrW-1:0] e2_q, e2_d;
  logic signed [AccW-1:0] acc_q, acc_d;

  logic signed [ErrW-1:0]  e_raw, e;
  logic signed [ErrW:0]    de1;
  logic signed [ErrW+1:0]  dd;
  logic signed [ProdW-1:0] p_prod, i_prod, d_prod;
  logic signed [SumW-1:0]  p_s, i_s, i_c, d_s;
  logic signed [SumW-1:0]  ilim, olim, sum, sum_c;
  logic                    hit_o;
  logic signed [AccW:0]    rnd;

  // Error with wrap correction
  always_comb begin
    e_raw = ErrW'(item_i.target) - ErrW'(item_i.measured);
    if (e_raw < -WrapThresh) begin
      e = e_raw + $signed(ErrW'(cfg_i.counts_per_turn));
    end else if (e_raw > WrapThresh) begin
      e = e_raw - $signed(ErrW'(cfg_i.counts_per_turn));
    end else begin
      e = e_raw;
    end
  end

  // Difference terms and the three gain products
  always_comb begin
    de1    = (ErrW+1)'(e) - (ErrW+1)'(e1_q);
    dd     = (ErrW+2)'(e) - ((ErrW+2)'(e1_q) <<< 1) + (ErrW+2)'(e2_q);
    p_prod = $signed({1'b0, cfg_i.kp}) * de1;
    i_prod = $signed({1'b0, cfg_i.ki}) * e;
    d_prod = $signed({1'b0, cfg_i.kd}) * dd;
    p_s    = SumW'(p_prod);
    i_s    = SumW'(i_prod);
    d_s    = SumW'(d_prod);
  end

  // Integral clamp, accumulate, output clamp
  always_comb begin
    ilim = $signed(SumW'(cfg_i.integral_limit) << FRAC_BITS);
    olim = $signed(SumW'(cfg_i.output_limit) << FRAC_BITS);
    if (i_s > ilim) begin
      i_c = ilim;
    end else if (i_s < -ilim) begin
      i_c = -ilim;
    end else begin
      i_c = i_s;
    end
    sum   = SumW'(acc_q) + p_s + i_c + d_s;
    hit_o = 1'b0;
    if (sum > olim) begin
      sum_c = olim;
      hit_o = 1'b1;
    end else if (sum < -olim) begin
      sum_c = -olim;
      hit_o = 1'b1;
    end else begin
      sum_c = sum;
    end
  end

  // Next state and result; clear zeroes everything
  always_comb begin
    if (item_i.action) begin
      acc_d = '0;
      e1_d  = '0;
      e2_d  = '0;
    end else begin
      acc_d = sum_c[AccW-1:0];
      e1_d  = e;
      e2_d  = e1_q;
    end
    // integer part, truncated toward zero
    rnd = (AccW+1)'(acc_d) + (acc_d[AccW-1] ? FracMask : '0);
    res_o.drive   = PosW'(rnd >>> FRAC_BITS);
    res_o.clamped = hit_o & ~item_i.action;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      e1_q  <= '0;
      e2_q  <= '0;
    end else if (step_i) begin
      acc_q <= acc_d;
      e1_q  <= e1_d;
      e2_q  <= e2_d;
    end
  end

endmodule

[rtl/incremental_pid_with_wrap.sv]
// Top level: stream handshake, configuration registers and result register.
// A transfer accepted sits in the input register; its result is registered in the
// result register when the input stage advances and can leave from there.
// Throughput: one item per cycle unless the result side stalls; the error history and
// drive accumulator update in the same cycle the item moves into the result register.
// Reset: gains 0, integral limit 32767, output limit 16384, counts per turn 8192,
// error history and accumulator zero, both stages empty.
`timescale 1ns / 1ps

module incremental_pid_with_wrap import ipid_pkg::*; #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // [15:0] target, [31:16] measured
  input  logic                s_axis_tuser,   // [0] action
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // [15:0] drive
  output logic                m_axis_tuser    // [0] clamped
);

  ipid_cfg_t  cfg_q;
  ipid_item_t item_q;
  ipid_res_t  res, res_q;
  logic       in_valid_q, out_valid_q;
  logic       adv, accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp              <= '0;
      cfg_q.ki              <= '0;
      cfg_q.kd              <= '0;
      cfg_q.integral_limit  <= 15'd32767;
      cfg_q.output_limit    <= 15'd16384;
      cfg_q.counts_per_turn <= 16'd8192;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KP:        cfg_q.kp              <= cfg_data_i[GainW-1:0];
        CFG_KI:        cfg_q.ki              <= cfg_data_i[GainW-1:0];
        CFG_KD:        cfg_q.kd              <= cfg_data_i[GainW-1:0];
        CFG_INT_LIMIT: cfg_q.integral_limit  <= cfg_data_i[LimW-1:0];
        CFG_OUT_LIMIT: cfg_q.output_limit    <= cfg_data_i[LimW-1:0];
        CFG_COUNTS:    cfg_q.counts_per_turn <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: input stage advances when the result register is free
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action   <= s_axis_tuser;
      item_q.target   <= $signed(s_axis_tdata[15:0]);
      item_q.measured <= $signed(s_axis_tdata[31:16]);
    end
    if (adv) begin
      res_q <= res;
    end
  end

  ipid_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q.drive;
  assign m_axis_tuser  = res_q.clamped;

  // A clear step leaves a zero result
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && item_q.action) |=> (res_q.drive == '0 && !res_q.clamped))
    else $error("clear step gave a nonzero result");

  // An empty input stage always takes a transfer
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stage empty but not ready");

  // A result only appears after the input stage advanced
  a_out_from_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv))
    else $error("result valid without an advancing item");

  // A saturated result sits exactly at the output bound
  a_clamp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.clamped) |->
      (res_q.drive == $signed({1'b0, cfg_q.output_limit}) ||
       res_q.drive == -$signed({1'b0, cfg_q.output_limit})))
    else $error("saturated drive not at the output bound");

endmodule

[bench/tb.sv]
// Self-checking testbench for the incremental PID block with encoder wrap correction.
`timescale 1ns / 1ps

module tb import ipid_pkg::*; ();

  localparam int unsigned FracBits = 8;
  localparam int unsigned QuietLimit = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;   // [15:0] target, [31:16] measured
  logic                s_axis_tuser;   // [0] action
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;   // [15:0] drive
  logic                m_axis_tuser;   // [0] clamped

  // Predictor copy of the registers and the loop state
  logic [GainW-1:0]         gain_p, gain_i, gain_d;
  logic [LimW-1:0]          int_bound, out_bound;
  logic [CountW-1:0]        turn_counts;
  logic signed [ErrW-1:0]   err_last, err_older;
  logic signed [23:0]       drive_acc;

  ipid_res_t drive_q[$];
  int unsigned n_fail;
  int unsigned quiet_cycles;
  logic no_gaps;

  incremental_pid_with_wrap #(
    .FRAC_BITS(FracBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog: too many cycles without any transfer or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Work out the result of one accepted item and queue it
  task automatic predict_drive(input logic act, input logic signed [15:0] tgt,
                               input logic signed [15:0] meas);
    longint err, p_term, i_term, d_term, total, ilim, olim, acc_now, whole;
    logic hit;
    ipid_res_t res;
    if (act) begin
      err_last  = '0;
      err_older = '0;
      drive_acc = '0;
      res.drive   = '0;
      res.clamped = 1'b0;
    end else begin
      err = longint'(tgt) - longint'(meas);
      // fold back one encoder turn when the error jumps past the threshold
      if (err < -longint'(WrapThresh)) err += longint'(turn_counts);
      else if (err > longint'(WrapThresh)) err -= longint'(turn_counts);

      p_term = longint'(gain_p) * (err - longint'(err_last));
      i_term = longint'(gain_i) * err;
      d_term = longint'(gain_d) * (err - 2 * longint'(err_last) + longint'(err_older));

      ilim = longint'(int_bound) << FracBits;
      olim = longint'(out_bound) << FracBits;
      if (i_term > ilim) i_term = ilim;
      else if (i_term < -ilim) i_term = -ilim;

      total = longint'(drive_acc) + p_term + i_term + d_term;
      hit = 1'b0;
      if (total > olim) begin
        total = olim;
        hit = 1'b1;
      end else if (total < -olim) begin
        total = -olim;
        hit = 1'b1;
      end
      drive_acc = total[23:0];
      err_older = err_last;
      err_last  = err[ErrW-1:0];

      // integer part, truncated toward zero
      acc_now = longint'(drive_acc);
      if (acc_now < 0) whole = -((-acc_now) >>> FracBits);
      else whole = acc_now >>> FracBits;
      res.drive   = whole[15:0];
      res.clamped = hit;
    end
    drive_q.push_back(res);
  endtask

  // Send one item; returns at the edge where it is accepted
  task automatic send_item(input logic act, input logic signed [15:0] tgt,
                           input logic signed [15:0] meas);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {meas, tgt};
    s_axis_tuser  = act;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_drive(act, tgt, meas);
  endtask

  // Stop sending and wait until every expected result has arrived
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    case (idx)
      CFG_KP:        gain_p      = val;
      CFG_KI:        gain_i      = val;
      CFG_KD:        gain_d      = val;
      CFG_INT_LIMIT: int_bound   = val[LimW-1:0];
      CFG_OUT_LIMIT: out_bound   = val[LimW-1:0];
      CFG_COUNTS:    turn_counts = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic write_all(input logic [15:0] kp, input logic [15:0] ki,
                           input logic [15:0] kd, input logic [15:0] ilim,
                           input logic [15:0] olim, input logic [15:0] cpt);
    write_reg(CFG_KP, kp);
    write_reg(CFG_KI, ki);
    write_reg(CFG_KD, kd);
    write_reg(CFG_INT_LIMIT, ilim);
    write_reg(CFG_OUT_LIMIT, olim);
    write_reg(CFG_COUNTS, cpt);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      1:       return 16'($urandom_range(0, 512));
      2:       return 16'($urandom_range(0, 4096));
      default: return 16'($urandom);
    endcase
  endfunction

  // Bit 15 is outside the 15-bit limit registers and must be dropped
  function automatic logic [15:0] pick_limit();
    logic [15:0] val;
    case ($urandom_range(0, 3))
      0:       val = $urandom_range(0, 1) ? 16'h7fff : 16'h0000;
      1:       val = 16'($urandom_range(0, 400));
      default: val = 16'($urandom);
    endcase
    val[15] = 1'($urandom_range(0, 1));
    return val;
  endfunction

  function automatic logic [15:0] pick_counts();
    case ($urandom_range(0, 3))
      0:       return 16'd1;
      1:       return 16'hffff;
      2:       return 16'd8192;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_corner();
    case ($urandom_range(0, 3))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  task automatic random_item();
    logic signed [15:0] tgt, meas, delta;
    meas = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1:       delta = 16'($urandom);
      2, 3, 4, 5: delta = 16'($urandom_range(0, 600) - 300);
      6, 7: begin
        // errors around the wrap threshold
        delta = 16'($urandom_range(5990, 6010));
        if ($urandom_range(0, 1) != 0) delta = -delta;
      end
      8: begin
        meas  = pick_corner();
        delta = pick_corner() - meas;
      end
      default:    delta = 16'($urandom_range(0, 4000) - 2000);
    endcase
    tgt = meas + delta;
    send_item($urandom_range(0, 19) == 0, tgt, meas);
  endtask

  // Gains are zero after reset, so the drive must stay at zero
  task automatic test_reset_values();
    send_item(1'b0, 16'sd1000, -16'sd1000);
    send_item(1'b0, 16'sh7fff, 16'sh8000);
  endtask

  // Integral only: a sum exactly at the bound is not flagged, one beyond it is
  task automatic test_output_saturation();
    write_all(16'd0, 16'd256, 16'd0, 16'd32767, 16'd100, 16'd8192);
    send_item(1'b1, 16'sd0, 16'sd0);
    send_item(1'b0, 16'sd100, 16'sd0);
    send_item(1'b0, 16'sd100, 16'sd0);
    send_item(1'b0, 16'sh8000, 16'sh7fff);
    send_item(1'b1, 16'sd5, -16'sd5);
  endtask

  // With a unit proportional gain the drive follows the corrected error
  task automatic test_wrap_correction();
    write_all(16'd256, 16'd0, 16'd0, 16'd32767, 16'd32767, 16'd8192);
    send_item(1'b0, 16'sd6000, 16'sd0);
    send_item(1'b0, 16'sd6001, 16'sd0);
    send_item(1'b0, 16'sd0, 16'sd6000);
    send_item(1'b0, 16'sd0, 16'sd6001);
    send_item(1'b0, 16'sh7fff, 16'sh8000);
    send_item(1'b0, 16'sh8000, 16'sh7fff);
    // zero counts per turn leaves the error alone
    write_reg(CFG_COUNTS, 16'd0);
    send_item(1'b1, 16'sd0, 16'sd0);
    send_item(1'b0, 16'sd20000, -16'sd1000);
    send_item(1'b0, -16'sd20000, 16'sd1000);
  endtask

  task automatic test_full_scale();
    write_all(16'hffff, 16'hffff, 16'hffff, 16'd32767, 16'd32767, 16'hffff);
    send_item(1'b0, 16'sh7fff, 16'sh8000);
    send_item(1'b0, 16'sh8000, 16'sh7fff);
    send_item(1'b0, 16'sd0, 16'sd0);
  endtask

  // Zero bounds force the integral term and the accumulator to zero
  task automatic test_zero_limits();
    write_all(16'd256, 16'd256, 16'd256, 16'd0, 16'd0, 16'd8192);
    send_item(1'b0, 16'sd1000, 16'sd0);
    send_item(1'b0, -16'sd1000, 16'sd0);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      write_all(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
                pick_counts());
      for (int n = 0; n < 100; n++) begin
        if (n % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        if (phase == 2 && n == 50) wait_drained();
        random_item();
      end
    end
    no_gaps = 1'b0;
  endtask

  // Result side: random stalls, each transfer checked against the oldest expectation
  initial begin : result_check
    int unsigned stall;
    ipid_res_t want;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (drive_q.size() == 0) begin
        $error("unexpected result transfer: drive %0d clamped %0b",
               $signed(m_axis_tdata), m_axis_tuser);
        n_fail++;
      end else begin
        want = drive_q.pop_front();
        if (m_axis_tdata !== want.drive) begin
          $error("drive: expected %0d, got %0d", want.drive, $signed(m_axis_tdata));
          n_fail++;
        end
        if (m_axis_tuser !== want.clamped) begin
          $error("clamped: expected %0b, got %0b", want.clamped, m_axis_tuser);
          n_fail++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    n_fail        = 0;
    quiet_cycles  = 0;
    no_gaps       = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_KP;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    gain_p        = '0;
    gain_i        = '0;
    gain_d        = '0;
    int_bound     = 15'd32767;
    out_bound     = 15'd16384;
    turn_counts   = 16'd8192;
    err_last      = '0;
    err_older     = '0;
    drive_acc     = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_output_saturation();
    test_wrap_correction();
    test_full_scale();
    test_zero_limits();
    test_random_traffic();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ipid_pkg.sv
rtl/ipid_core.sv
rtl/incremental_pid_with_wrap.sv
bench/tb.sv
